/* rtl/core/sng_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sng_pkg;

  // Key and network geometry
  localparam int KEY_WIDTH        = 32;
  localparam int NUM_WIRES        = 8;
  localparam int NUM_LAYERS       = 6;
  localparam int LAYERS_PER_STAGE = 2;
  localparam int NUM_STAGES       = NUM_LAYERS / LAYERS_PER_STAGE;
  localparam int LAYER_WIDTH      = $clog2(NUM_LAYERS);

  // Configuration port geometry
  localparam int CFG_INDEX_WIDTH  = 1;
  localparam int CFG_DATA_WIDTH   = 4;
  localparam int WIRE_COUNT_WIDTH = 4;

  // Supported sizes and reset values
  localparam logic [WIRE_COUNT_WIDTH-1:0] WIRES_4   = 4'd4;
  localparam logic [WIRE_COUNT_WIDTH-1:0] WIRES_5   = 4'd5;
  localparam logic [WIRE_COUNT_WIDTH-1:0] WIRES_6   = 4'd6;
  localparam logic [WIRE_COUNT_WIDTH-1:0] WIRES_7   = 4'd7;
  localparam logic [WIRE_COUNT_WIDTH-1:0] WIRES_MAX = 4'd15;
  localparam logic [WIRE_COUNT_WIDTH-1:0] WIRE_COUNT_RESET  = 4'd8;
  localparam logic                        SIGNED_KEYS_RESET = 1'b0;

  typedef logic [KEY_WIDTH-1:0]                   key_t;
  typedef key_t [NUM_WIRES-1:0]                   keys_t;
  typedef logic [NUM_WIRES-1:0][NUM_WIRES-1:0]    pair_mask_t;
  typedef logic [LAYER_WIDTH-1:0]                 layer_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_WIRE_COUNT  = 1'd0,
    REG_SIGNED_KEYS = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    NET_NONE = 3'd0,
    NET_4    = 3'd1,
    NET_5    = 3'd2,
    NET_6    = 3'd3,
    NET_8    = 3'd4
  } net_t;

  // Per-item control that travels down the pipeline with the keys
  typedef struct packed {
    net_t net;
    logic signed_mode;
  } ctl_t;

  // Comparators of one layer of a network, as m[lo][hi]. Comparators in a
  // layer touch disjoint wires, and the layers keep the original order of
  // every pair of comparators that share a wire.
  function automatic pair_mask_t layer_pairs(net_t net, layer_t layer);
    pair_mask_t m;
    m = '0;
    case (net)
      NET_4: begin
        case (layer)
          3'd0: begin m[0][1] = 1'b1; m[2][3] = 1'b1; end
          3'd1: begin m[0][2] = 1'b1; m[1][3] = 1'b1; end
          3'd2: begin m[1][2] = 1'b1; end
          default: ;
        endcase
      end
      NET_5: begin
        case (layer)
          3'd0: begin m[0][1] = 1'b1; m[3][4] = 1'b1; end
          3'd1: begin m[2][4] = 1'b1; end
          3'd2: begin m[2][3] = 1'b1; m[1][4] = 1'b1; end
          3'd3: begin m[0][3] = 1'b1; end
          3'd4: begin m[0][2] = 1'b1; m[1][3] = 1'b1; end
          3'd5: begin m[1][2] = 1'b1; end
          default: ;
        endcase
      end
      NET_6: begin
        case (layer)
          3'd0: begin m[1][2] = 1'b1; m[4][5] = 1'b1; end
          3'd1: begin m[0][2] = 1'b1; m[3][5] = 1'b1; end
          3'd2: begin m[0][1] = 1'b1; m[3][4] = 1'b1; m[2][5] = 1'b1; end
          3'd3: begin m[0][3] = 1'b1; m[1][4] = 1'b1; end
          3'd4: begin m[2][4] = 1'b1; m[1][3] = 1'b1; end
          3'd5: begin m[2][3] = 1'b1; end
          default: ;
        endcase
      end
      NET_8: begin
        case (layer)
          3'd0: begin
            m[0][4] = 1'b1; m[1][5] = 1'b1; m[2][6] = 1'b1; m[3][7] = 1'b1;
          end
          3'd1: begin
            m[0][2] = 1'b1; m[1][3] = 1'b1; m[4][6] = 1'b1; m[5][7] = 1'b1;
          end
          3'd2: begin
            m[0][1] = 1'b1; m[2][4] = 1'b1; m[3][5] = 1'b1; m[6][7] = 1'b1;
          end
          3'd3: begin m[2][3] = 1'b1; m[4][5] = 1'b1; end
          3'd4: begin m[1][4] = 1'b1; m[3][6] = 1'b1; end
          3'd5: begin m[1][2] = 1'b1; m[3][4] = 1'b1; m[5][6] = 1'b1; end
          default: ;
        endcase
      end
      default: ;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sng_layer.sv */
`timescale 1ns / 1ps
`default_nettype none

// One layer of disjoint compare-exchange units
module sng_layer (
  input  sng_pkg::keys_t      keys_i,
  input  sng_pkg::pair_mask_t pairs_i,
  input  logic                signed_mode_i,
  output sng_pkg::keys_t      keys_o
);

  sng_pkg::key_t flip;

  // Flip the sign bit so signed order becomes unsigned order
  assign flip = {signed_mode_i, {(sng_pkg::KEY_WIDTH-1){1'b0}}};

  // Swap a pair only when the lower wire holds the strictly greater key
  always_comb begin
    keys_o = keys_i;
    for (int lo = 0; lo < sng_pkg::NUM_WIRES; lo++) begin
      for (int hi = lo + 1; hi < sng_pkg::NUM_WIRES; hi++) begin
        if (pairs_i[lo][hi] && ((keys_i[lo] ^ flip) > (keys_i[hi] ^ flip))) begin
          keys_o[lo] = keys_i[hi];
          keys_o[hi] = keys_i[lo];
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sorting_network_four_to_eight_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_stall     in_key_in_0 .. in_key_in_7
// out_      output     out_valid / out_stall   out_key_out_0 .. out_key_out_7
// cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transaction is taken every cycle while in_stall is low. Each of the
// three register stages runs two comparator layers of the selected network.
// Reset (synchronous, rst_n low) empties the pipeline and restores count 8,
// unsigned keys. A stall on the output holds the last stage, and the stall
// moves back only as far as the first empty stage.
module sorting_network_four_to_eight_core (
  input  logic                                    clk,
  input  logic                                    rst_n,

  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [31:0]                             in_key_in_0,
  input  logic [31:0]                             in_key_in_1,
  input  logic [31:0]                             in_key_in_2,
  input  logic [31:0]                             in_key_in_3,
  input  logic [31:0]                             in_key_in_4,
  input  logic [31:0]                             in_key_in_5,
  input  logic [31:0]                             in_key_in_6,
  input  logic [31:0]                             in_key_in_7,

  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [31:0]                             out_key_out_0,
  output logic [31:0]                             out_key_out_1,
  output logic [31:0]                             out_key_out_2,
  output logic [31:0]                             out_key_out_3,
  output logic [31:0]                             out_key_out_4,
  output logic [31:0]                             out_key_out_5,
  output logic [31:0]                             out_key_out_6,
  output logic [31:0]                             out_key_out_7,

  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [sng_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [sng_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

  localparam int LAST = sng_pkg::NUM_STAGES - 1;

  logic [sng_pkg::WIRE_COUNT_WIDTH-1:0] wire_count_r;
  logic                                 signed_keys_r;
  sng_pkg::ctl_t                        in_ctl;
  sng_pkg::keys_t                       in_keys;

  sng_pkg::keys_t                       stg_keys_r [sng_pkg::NUM_STAGES];
  sng_pkg::ctl_t                        stg_ctl_r  [sng_pkg::NUM_STAGES];
  logic [sng_pkg::NUM_STAGES-1:0]       stg_vld_r;
  logic [sng_pkg::NUM_STAGES-1:0]       advance;

  // Configuration registers; writes never wait
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wire_count_r  <= sng_pkg::WIRE_COUNT_RESET;
      signed_keys_r <= sng_pkg::SIGNED_KEYS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sng_pkg::REG_WIRE_COUNT:  wire_count_r  <= cfg_data;
        sng_pkg::REG_SIGNED_KEYS: signed_keys_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Decode the count into a network; seven and above run the full network
  always_comb begin
    in_ctl.signed_mode = signed_keys_r;
    case (wire_count_r) inside
      sng_pkg::WIRES_4:                       in_ctl.net = sng_pkg::NET_4;
      sng_pkg::WIRES_5:                       in_ctl.net = sng_pkg::NET_5;
      sng_pkg::WIRES_6:                       in_ctl.net = sng_pkg::NET_6;
      [sng_pkg::WIRES_7:sng_pkg::WIRES_MAX]:  in_ctl.net = sng_pkg::NET_8;
      default:                                in_ctl.net = sng_pkg::NET_NONE;
    endcase
  end

  // Gather the input keys
  assign in_keys[0] = in_key_in_0;
  assign in_keys[1] = in_key_in_1;
  assign in_keys[2] = in_key_in_2;
  assign in_keys[3] = in_key_in_3;
  assign in_keys[4] = in_key_in_4;
  assign in_keys[5] = in_key_in_5;
  assign in_keys[6] = in_key_in_6;
  assign in_keys[7] = in_key_in_7;

  // A stage moves when it is empty or the stage after it moves
  assign advance[LAST] = !stg_vld_r[LAST] || !out_stall;
  for (genvar s = 0; s < LAST; s++) begin : g_adv
    assign advance[s] = !stg_vld_r[s] || advance[s+1];
  end

  assign in_stall = !advance[0];

  // Pipeline stages, two comparator layers each
  for (genvar s = 0; s < sng_pkg::NUM_STAGES; s++) begin : g_stage
    sng_pkg::keys_t src_keys;
    sng_pkg::ctl_t  src_ctl;
    logic           src_vld;
    sng_pkg::keys_t mid_keys;
    sng_pkg::keys_t stg_keys_nxt;

    if (s == 0) begin : g_first
      assign src_keys = in_keys;
      assign src_ctl  = in_ctl;
      assign src_vld  = in_valid;
    end else begin : g_next
      assign src_keys = stg_keys_r[s-1];
      assign src_ctl  = stg_ctl_r[s-1];
      assign src_vld  = stg_vld_r[s-1];
    end

    sng_layer u_layer_a (
      .keys_i        (src_keys),
      .pairs_i       (sng_pkg::layer_pairs(src_ctl.net,
                        sng_pkg::layer_t'(s * sng_pkg::LAYERS_PER_STAGE))),
      .signed_mode_i (src_ctl.signed_mode),
      .keys_o        (mid_keys)
    );

    sng_layer u_layer_b (
      .keys_i        (mid_keys),
      .pairs_i       (sng_pkg::layer_pairs(src_ctl.net,
                        sng_pkg::layer_t'(s * sng_pkg::LAYERS_PER_STAGE + 1))),
      .signed_mode_i (src_ctl.signed_mode),
      .keys_o        (stg_keys_nxt)
    );

    // Advance the valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_vld_r[s] <= 1'b0;
      end else if (advance[s]) begin
        stg_vld_r[s] <= src_vld;
      end
    end

    // Advance the payload; hold it while stalled
    always_ff @(posedge clk) begin
      if (advance[s]) begin
        stg_keys_r[s] <= stg_keys_nxt;
        stg_ctl_r[s]  <= src_ctl;
      end
    end
  end

  // Drive the result channel from the last stage
  assign out_valid     = stg_vld_r[LAST];
  assign out_key_out_0 = stg_keys_r[LAST][0];
  assign out_key_out_1 = stg_keys_r[LAST][1];
  assign out_key_out_2 = stg_keys_r[LAST][2];
  assign out_key_out_3 = stg_keys_r[LAST][3];
  assign out_key_out_4 = stg_keys_r[LAST][4];
  assign out_key_out_5 = stg_keys_r[LAST][5];
  assign out_key_out_6 = stg_keys_r[LAST][6];
  assign out_key_out_7 = stg_keys_r[LAST][7];

endmodule

`default_nettype wire
